/* rtl/core/wes_pkg.sv */
// Shared constants, command codes and status types for the wave grid stencil.
package wes_pkg;

  // Grid and value geometry.
  localparam int GRID_MAX = 64;
  localparam int IDX_W    = 6;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int VALUE_W  = 32;
  localparam int GS_W     = 7;
  localparam int COEF_W   = 16;
  localparam int CFG_W    = 16;

  // Reset values of the configuration registers.
  localparam logic [GS_W-1:0]   GS_RESET   = GS_W'(64);
  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(164);
  localparam logic [GS_W-1:0]   GS_MIN     = GS_W'(3);
  localparam logic [GS_W-1:0]   GS_MAX     = GS_W'(GRID_MAX);

  // Configuration register indexes.
  localparam logic CFG_GRID_SIZE = 1'b0;
  localparam logic CFG_COEF      = 1'b1;

  // Operation codes; the last one is unused and gives an empty result.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_CELL,
    CMD_RD_CAP,
    CMD_STEP_START,
    CMD_NS,
    CMD_WE,
    CMD_U,
    CMD_SUM,
    CMD_MUL,
    CMD_WR,
    CMD_ZERO,
    CMD_FLIP,
    CMD_RESULT
  } dp_cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       cell_edge;
    logic       cell_last;
  } dp_status_t;

endpackage

/* rtl/core/wes_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module wes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

/* rtl/core/wes_datapath.sv */
// Datapath: grid planes, configuration registers, cell counter and update arithmetic.
module wes_datapath import wes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_e             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]          opcode_i,
  input  logic [IDX_W-1:0]    row_i,
  input  logic [IDX_W-1:0]    col_i,
  input  logic [VALUE_W-1:0]  cell_value_i,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic                saturated_o
);

  localparam int NS_W   = VALUE_W + 1;
  localparam int NB_W   = VALUE_W + 2;
  localparam int S_W    = VALUE_W + 3;
  localparam int PROD_W = S_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  // Configuration and control flags.
  logic [GS_W-1:0]   grid_size_q;
  logic [COEF_W-1:0] coef_q;
  logic              cur_b_q;
  logic              first_q;
  logic              sat_q;
  logic [ADDR_W-1:0] cnt_q;

  // Latched operation.
  logic [1:0]         op_q;
  logic [IDX_W-1:0]   row_q;
  logic [IDX_W-1:0]   col_q;
  logic [VALUE_W-1:0] val_q;

  // Arithmetic pipeline registers.
  logic signed [NS_W-1:0]    ns_q;
  logic signed [NS_W-1:0]    ew_q;
  logic signed [VALUE_W-1:0] prev_q;
  logic signed [VALUE_W-1:0] u_q;
  logic signed [S_W-1:0]     s_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [VALUE_W-1:0]        rd_q;

  // Result register.
  logic [VALUE_W-1:0] res_val_q;
  logic               res_sat_q;

  logic [GS_W-1:0]   n_act;
  logic [IDX_W-1:0]  ci;
  logic [IDX_W-1:0]  cj;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] pos_addr;

  // RAM port roles.
  logic              cur_we;
  logic              nxt_we;
  logic [ADDR_W-1:0] waddr;
  logic [VALUE_W-1:0] wdata;
  logic [ADDR_W-1:0] cur_ra0;
  logic [ADDR_W-1:0] cur_ra1;
  logic [ADDR_W-1:0] nxt_ra0;
  logic [VALUE_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [VALUE_W-1:0] cur_rd0, cur_rd1, nxt_rd0;

  logic signed [NB_W-1:0]   nb;
  logic signed [S_W-1:0]    s_d;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  v;
  logic                     v_sat;
  logic [VALUE_W-1:0]       v_clamped;

  // Active grid side, clamped to the legal range.
  always_comb begin
    if (grid_size_q < GS_MIN) begin
      n_act = GS_MIN;
    end else if (grid_size_q > GS_MAX) begin
      n_act = GS_MAX;
    end else begin
      n_act = grid_size_q;
    end
  end

  assign ci        = cnt_q[ADDR_W-1:IDX_W];
  assign cj        = cnt_q[IDX_W-1:0];
  assign cell_addr = {row_q, col_q};
  assign pos_addr  = cnt_q;

  // Status towards the controller.
  assign status_o.op        = op_q;
  assign status_o.in_range  = ({1'b0, row_q} < n_act) && ({1'b0, col_q} < n_act);
  assign status_o.cell_edge = ({1'b0, ci} >= n_act) || ({1'b0, cj} >= n_act) ||
                              (ci == '0) || (cj == '0) ||
                              ({1'b0, ci} == n_act - GS_W'(1)) ||
                              ({1'b0, cj} == n_act - GS_W'(1));
  assign status_o.cell_last = (cnt_q == ADDR_W'(CELLS - 1));

  // Update arithmetic.
  assign nb      = NB_W'(ns_q) + NB_W'(ew_q);
  assign s_d     = first_q ? S_W'(nb) : (S_W'(nb) - (S_W'(signed'(cur_rd0)) <<< 2));
  assign prod_d  = PROD_W'(s_q) * PROD_W'(signed'({1'b0, coef_q}));
  assign prod_sh = first_q ? (prod_q >>> (COEF_W + 1)) : (prod_q >>> COEF_W);
  assign v       = first_q ? (SUM_W'(u_q) + SUM_W'(prod_sh))
                           : (SUM_W'(u_q) - SUM_W'(prev_q) + SUM_W'(prod_sh));
  assign v_sat   = !((&v[SUM_W-1:VALUE_W-1]) || !(|v[SUM_W-1:VALUE_W-1]));
  assign v_clamped = v_sat ? (v[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                         : {1'b0, {(VALUE_W-1){1'b1}}})
                           : v[VALUE_W-1:0];

  // RAM command decode.
  always_comb begin
    cur_we  = 1'b0;
    nxt_we  = 1'b0;
    waddr   = pos_addr;
    wdata   = '0;
    cur_ra0 = '0;
    cur_ra1 = '0;
    nxt_ra0 = '0;
    case (cmd_i)
      CMD_CLEAR: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
      end
      CMD_LOAD: begin
        cur_we = status_o.in_range;
        waddr  = cell_addr;
        wdata  = val_q;
      end
      CMD_RD_CELL: begin
        cur_ra0 = cell_addr;
      end
      CMD_NS: begin
        cur_ra0 = {ci - IDX_W'(1), cj};
        cur_ra1 = {ci + IDX_W'(1), cj};
        nxt_ra0 = pos_addr;
      end
      CMD_WE: begin
        cur_ra0 = {ci, cj - IDX_W'(1)};
        cur_ra1 = {ci, cj + IDX_W'(1)};
      end
      CMD_U: begin
        cur_ra0 = pos_addr;
      end
      CMD_WR: begin
        nxt_we = 1'b1;
        wdata  = v_clamped;
      end
      CMD_ZERO: begin
        nxt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Plane A and plane B, mapped to current and next roles.
  wes_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_plane_a (
    .clk_i    (clk_i),
    .we_i     (cur_b_q ? nxt_we : cur_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (cur_b_q ? nxt_ra0 : cur_ra0),
    .raddr1_i (cur_ra1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  wes_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_plane_b (
    .clk_i    (clk_i),
    .we_i     (cur_b_q ? cur_we : nxt_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (cur_b_q ? cur_ra0 : nxt_ra0),
    .raddr1_i (cur_ra1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  assign cur_rd0 = cur_b_q ? b_rd0 : a_rd0;
  assign cur_rd1 = cur_b_q ? b_rd1 : a_rd1;
  assign nxt_rd0 = cur_b_q ? a_rd0 : b_rd0;

  // Control state: configuration, flags and the cell counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GS_RESET;
      coef_q      <= COEF_RESET;
      cur_b_q     <= 1'b0;
      first_q     <= 1'b1;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OP_LOAD;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_SIZE: grid_size_q <= cfg_data_i[GS_W-1:0];
          CFG_COEF:      coef_q      <= cfg_data_i[COEF_W-1:0];
          default: begin
          end
        endcase
      end
      case (cmd_i)
        CMD_LATCH:      op_q <= opcode_i;
        CMD_CLEAR:      cnt_q <= cnt_q + ADDR_W'(1);
        CMD_LOAD: begin
          if (status_o.in_range) begin
            first_q <= 1'b1;
          end
        end
        CMD_STEP_START: begin
          cnt_q <= '0;
          sat_q <= 1'b0;
        end
        CMD_WR: begin
          cnt_q <= cnt_q + ADDR_W'(1);
          if (v_sat) begin
            sat_q <= 1'b1;
          end
        end
        CMD_ZERO:       cnt_q <= cnt_q + ADDR_W'(1);
        CMD_FLIP: begin
          cur_b_q <= !cur_b_q;
          first_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LATCH: begin
        row_q <= row_i;
        col_q <= col_i;
        val_q <= cell_value_i;
      end
      CMD_RD_CAP: rd_q <= cur_rd0;
      CMD_WE: begin
        ns_q   <= NS_W'(signed'(cur_rd0)) + NS_W'(signed'(cur_rd1));
        prev_q <= signed'(nxt_rd0);
      end
      CMD_U:   ew_q <= NS_W'(signed'(cur_rd0)) + NS_W'(signed'(cur_rd1));
      CMD_SUM: begin
        u_q <= signed'(cur_rd0);
        s_q <= s_d;
      end
      CMD_MUL: prod_q <= prod_d;
      CMD_RESULT: begin
        res_val_q <= (op_q == OP_READ && status_o.in_range) ? rd_q : '0;
        res_sat_q <= (op_q == OP_STEP) ? sat_q : 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign read_value_o = res_val_q;
  assign saturated_o  = res_sat_q;

endmodule

/* rtl/core/wes_ctrl.sv */
// Controller: sequences clearing, operations, the grid sweep and the result beat.
module wes_ctrl import wes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RCAP,
    S_CELL,
    S_WE,
    S_U,
    S_SUM,
    S_MUL,
    S_WR,
    S_FLIP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command.
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.cell_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.op)
          OP_LOAD: begin
            cmd_o   = CMD_LOAD;
            state_d = S_DONE;
          end
          OP_READ: begin
            cmd_o   = CMD_RD_CELL;
            state_d = S_RCAP;
          end
          OP_STEP: begin
            cmd_o   = CMD_STEP_START;
            state_d = S_CELL;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RCAP: begin
        cmd_o   = CMD_RD_CAP;
        state_d = S_DONE;
      end
      S_CELL: begin
        if (status_i.cell_edge) begin
          cmd_o = CMD_ZERO;
          if (status_i.cell_last) begin
            state_d = S_FLIP;
          end
        end else begin
          cmd_o   = CMD_NS;
          state_d = S_WE;
        end
      end
      S_WE: begin
        cmd_o   = CMD_WE;
        state_d = S_U;
      end
      S_U: begin
        cmd_o   = CMD_U;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o   = CMD_SUM;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o   = CMD_MUL;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o   = CMD_WR;
        state_d = status_i.cell_last ? S_FLIP : S_CELL;
      end
      S_FLIP: begin
        cmd_o   = CMD_FLIP;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o       = CMD_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/wave_equation_grid_stencil.sv */
// Top level of the two-dimensional wave-equation grid stencil.
//
// Input channel (in_valid_i / in_stall_o) carries one op per beat: load a
// cell, advance the grid one time step, or read a cell. Every op gives one
// result beat on the output channel (out_valid_o / out_stall_i) with
// read_value_o and saturated_o; fields not meaningful for the op are zero.
// After reset the block runs a clearing pass over both 4096-cell planes with
// in_stall_o high; configuration writes are taken meanwhile. Ops are handled
// one at a time. For a load the op is latched, the decode state writes the
// cell and the done state loads the result register; a read adds a capture
// state after decode. The next op is taken once the block is back in idle.
// A step sweeps all 4096 cell positions: an edge or unused cell is zeroed in
// the cell state alone, and an interior cell passes through the cell, WE, U,
// sum, multiply and write states, set by the single read port pair of the
// plane memories. The result is held in an output register, so a new op is
// accepted while the previous result waits; when the receiver stalls and a
// second result is ready, the block waits with in_stall_o high.
module wave_equation_grid_stencil import wes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [IDX_W-1:0]    row_i,
  input  logic [IDX_W-1:0]    col_i,
  input  logic [VALUE_W-1:0]  cell_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic                saturated_o
);

  dp_cmd_e    cmd;
  dp_status_t status;

  // Sequencer.
  wes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  // Planes and arithmetic.
  wes_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cell_value_i (cell_value_i),
    .read_value_o (read_value_o),
    .saturated_o  (saturated_o)
  );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the wave-equation grid stencil, with its own grid predictor.
`timescale 1ns / 100ps

module tb;
  import wes_pkg::*;

  localparam int  STALL_LIMIT = 200000;
  localparam int  HOLD_CYCLES = 300;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  // One row of the directed stimulus; a row may first set both registers.
  typedef struct {
    bit          set_cfg;
    logic [6:0]  gs;
    logic [15:0] coef;
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
    bit          fixed;
    logic [31:0] rd;
    logic        sat;
  } grid_op_t;

  typedef struct {
    logic [31:0] rd;
    logic        sat;
  } grid_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = CFG_GRID_SIZE;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = OP_READ;
  logic [IDX_W-1:0] row_i = '0;
  logic [IDX_W-1:0] col_i = '0;
  logic [VALUE_W-1:0] cell_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VALUE_W-1:0] read_value_o;
  logic saturated_o;

  wave_equation_grid_stencil i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: two planes, the current selector, first-step flag, registers.
  longint      height_plane [2][CELLS];
  bit          cur_sel;
  bit          first_pending;
  logic [6:0]  model_gs;
  logic [15:0] model_coef;

  grid_op_t     op_queue [$];
  grid_result_t expected_results [$];
  int  mismatch_count = 0;
  bit  hold_req = 1'b0;
  int  burst_left = 0;

  grid_op_t directed_table [26] = '{
    '{0, 0, 0, OP_READ, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, OP_READ, 63, 63, 0, 1, 0, 0},
    '{0, 0, 0, OP_UNUSED, 63, 63, 32'hFFFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 63, 63, 32'h80000000, 1, 0, 0},
    '{0, 0, 0, OP_READ, 63, 63, 0, 1, 32'h80000000, 0},
    '{0, 0, 0, OP_LOAD, 62, 1, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_STEP, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, OP_READ, 62, 1, 0, 0, 0, 0},
    '{1, 7'd3, 16'd32768, OP_LOAD, 1, 1, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 0, 1, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 1, 0, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 1, 2, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 2, 1, 32'h7FFFFFFF, 1, 0, 0},
    '{0, 0, 0, OP_LOAD, 5, 5, 32'h00001234, 1, 0, 0},
    '{0, 0, 0, OP_READ, 5, 5, 0, 1, 0, 0},
    '{0, 0, 0, OP_STEP, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, OP_READ, 1, 1, 0, 1, 32'h7FFFFFFF, 0},
    '{0, 0, 0, OP_READ, 0, 1, 0, 1, 0, 0},
    '{0, 0, 0, OP_STEP, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, OP_READ, 1, 1, 0, 0, 0, 0},
    '{1, 7'd0, 16'd0, OP_LOAD, 2, 2, 32'h80000000, 1, 0, 0},
    '{0, 0, 0, OP_STEP, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, OP_READ, 2, 2, 0, 1, 0, 0},
    '{1, 7'd4, 16'hFFFF, OP_LOAD, 1, 1, 32'h80000000, 1, 0, 0},
    '{0, 0, 0, OP_STEP, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, OP_READ, 1, 1, 0, 0, 0, 0}
  };

  function automatic int active_side();
    int n;
    n = int'(model_gs);
    if (n < 3) n = 3;
    if (n > GRID_MAX) n = GRID_MAX;
    return n;
  endfunction

  function automatic longint clamp_height(longint v, inout bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  // Applies one op to the predicted grid and returns the result beat it gives.
  function automatic grid_result_t apply_grid_op(grid_op_t g);
    grid_result_t r;
    int n, p;
    bit sat, unused;
    longint u, nb, v, k;
    bit nx;
    r.rd = '0;
    r.sat = 1'b0;
    n = active_side();
    sat = 1'b0;
    nx = ~cur_sel;
    k = longint'(model_coef);
    if (g.op == OP_LOAD) begin
      if (g.row < n && g.col < n) begin
        height_plane[cur_sel][g.row * GRID_MAX + g.col] =
          clamp_height(longint'(signed'(g.value)), unused);
        first_pending = 1'b1;
      end
    end else if (g.op == OP_READ) begin
      if (g.row < n && g.col < n)
        r.rd = 32'(height_plane[cur_sel][g.row * GRID_MAX + g.col]);
    end else if (g.op == OP_STEP) begin
      for (int i = 0; i < GRID_MAX; i++) begin
        for (int j = 0; j < GRID_MAX; j++) begin
          p = i * GRID_MAX + j;
          if (i >= n || j >= n || i == 0 || j == 0 || i == n - 1 || j == n - 1) begin
            height_plane[nx][p] = 0;
          end else begin
            u = height_plane[cur_sel][p];
            nb = height_plane[cur_sel][p - GRID_MAX] + height_plane[cur_sel][p + GRID_MAX]
               + height_plane[cur_sel][p - 1] + height_plane[cur_sel][p + 1];
            // Products fit in 64 bits, so an arithmetic shift gives the floor.
            if (first_pending)
              v = u + (((nb * k) >>> 16) >>> 1);
            else
              v = u - height_plane[nx][p] + (((nb - 4 * u) * k) >>> 16);
            height_plane[nx][p] = clamp_height(v, sat);
          end
        end
      end
      cur_sel = nx;
      first_pending = 1'b0;
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic write_register(logic idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GRID_SIZE) model_gs = data[6:0];
    else model_coef = data;
  endtask

  // Offers every queued op in bursts with random gaps, predicting each accepted beat.
  task automatic send_ops();
    grid_op_t g;
    grid_result_t r;
    int gap;
    while (op_queue.size() != 0) begin
      g = op_queue.pop_front();
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      opcode_i <= g.op;
      row_i <= g.row;
      col_i <= g.col;
      cell_value_i <= g.value;
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (in_stall_o);
      r = apply_grid_op(g);
      if (g.fixed) begin
        r.rd = g.rd;
        r.sat = g.sat;
      end
      expected_results.push_back(r);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_height();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  // Random ops for one phase; most cells fall inside the active square.
  task automatic queue_random_ops(int count, int max_steps);
    grid_op_t g;
    int n, pick, steps;
    n = active_side();
    steps = 0;
    for (int i = 0; i < count; i++) begin
      g = '{default: '0};
      pick = $urandom_range(0, 99);
      if (pick < 45) g.op = OP_LOAD;
      else if (pick < 75) g.op = OP_READ;
      else if (pick < 95 && steps < max_steps) g.op = OP_STEP;
      else g.op = OP_UNUSED;
      if (g.op == OP_STEP) steps++;
      if ($urandom_range(0, 99) < 85) begin
        g.row = 6'($urandom_range(0, n - 1));
        g.col = 6'($urandom_range(0, n - 1));
      end else begin
        g.row = 6'($urandom);
        g.col = 6'($urandom);
      end
      g.value = random_height();
      op_queue.push_back(g);
    end
  endtask

  // Result checker: each beat against the oldest expectation.
  always @(posedge clk_i) begin
    grid_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", read_value_o, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (read_value_o !== want.rd) report_mismatch("read_value", read_value_o, want.rd);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
      end
    end
  end

  // Receiver: random stall pattern whose stall rate changes at random moments, plus one long hold when asked.
  initial begin
    int pct;
    pct = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      out_stall_i <= ($urandom_range(0, 99) < pct);
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk_i) begin
    int idle_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    static logic [6:0] sizes [8] = '{7'd0, 7'd4, 7'd5, 7'd8, 7'd127, 7'd6, 7'd3, 7'd10};
    logic [15:0] coef;
    for (int c = 0; c < CELLS; c++) begin
      height_plane[0][c] = 0;
      height_plane[1][c] = 0;
    end
    cur_sel = 1'b0;
    first_pending = 1'b1;
    model_gs = GS_RESET;
    model_coef = COEF_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset contents, extremes, edge clearing, saturation.
    foreach (directed_table[i]) begin
      if (directed_table[i].set_cfg) begin
        send_ops();
        drain();
        write_register(CFG_GRID_SIZE, {9'h0, directed_table[i].gs});
        write_register(CFG_COEF, directed_table[i].coef);
      end
      op_queue.push_back(directed_table[i]);
    end
    send_ops();
    drain();

    // Random phases, each under a new register setting.
    foreach (sizes[ph]) begin
      case (ph % 4)
        0: coef = 16'h0000;
        1: coef = 16'h8000;
        2: coef = 16'hFFFF;
        default: coef = 16'($urandom);
      endcase
      write_register(CFG_GRID_SIZE, {9'($urandom), sizes[ph]});
      write_register(CFG_COEF, coef);
      if (ph == 2) hold_req = 1'b1;
      queue_random_ops(15, (sizes[ph] >= 64) ? 1 : 6);
      send_ops();
      drain();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
